// ===== hdl/triangle_scanline_span_defines.svh =====
// ----------------------------------------------------------------------------
// Triangle scanline span assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_SCANLINE_SPAN_DEFINES_SVH
`define TRIANGLE_SCANLINE_SPAN_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TSS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle scanline span package
// Coordinate types, stage records and the shared edge and divider functions.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int COORD_BITS = 12;
    localparam int PROD_BITS = 2 * COORD_BITS;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = (COORD_BITS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [PROD_BITS-1:0] prod_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vertex_t;

    typedef struct packed {
        vertex_t a;
        vertex_t b;
        vertex_t c;
        coord_t  row;
    } query_t;

    typedef struct packed {
        vertex_t top;
        vertex_t mid;
        vertex_t bot;
        coord_t  row;
        logic    covered;
        logic    upper;
    } sorted_t;

    typedef struct packed {
        logic   neg;
        coord_t ax;
        coord_t mag;
        coord_t dr;
        coord_t dvs;
    } prep_t;

    typedef struct packed {
        logic  covered;
        prep_t e1;
        prep_t e2;
    } prep_stage_t;

    typedef struct packed {
        logic   neg;
        coord_t ax;
        coord_t dvs;
        coord_t rem;
        coord_t num;
    } lane_t;

    typedef struct packed {
        logic  covered;
        lane_t e1;
        lane_t e2;
    } div_stage_t;

    // Sets up one edge: magnitude and sign of the x delta, row offset and
    // divisor. A flat edge gets a zero delta and a unit divisor.
    function automatic prep_t edge_prep(vertex_t va, vertex_t vb, coord_t row);
        logic [COORD_BITS:0] dxw;
        prep_t p;
        dxw = {1'b0, vb.x} - {1'b0, va.x};
        p.neg = dxw[COORD_BITS];
        p.ax = va.x;
        p.dr = row - va.y;
        if (va.y == vb.y)
        begin
            p.mag = '0;
            p.dvs = coord_t'(1);
        end
        else
        begin
            p.mag = p.neg ? coord_t'(~dxw + 1'b1) : dxw[COORD_BITS-1:0];
            p.dvs = vb.y - va.y;
        end
        return p;
    endfunction

    // One restoring division step; quotient bits shift into the low end.
    function automatic lane_t div_step(lane_t l);
        logic [COORD_BITS:0] t;
        logic [COORD_BITS:0] d;
        lane_t r;
        t = {l.rem, l.num[COORD_BITS-1]};
        d = {1'b0, l.dvs};
        r = l;
        if (t >= d)
        begin
            r.rem = coord_t'(t - d);
            r.num = {l.num[COORD_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[COORD_BITS-1:0];
            r.num = {l.num[COORD_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    // Applies the truncated quotient to the edge's start x.
    function automatic coord_t lane_x(lane_t l);
        logic [COORD_BITS:0] s;
        s = l.neg ? ({1'b0, l.ax} - {1'b0, l.num}) : ({1'b0, l.ax} + {1'b0, l.num});
        return s[COORD_BITS-1:0];
    endfunction

endpackage

// ===== hdl/triangle_scanline_span.sv =====
// ----------------------------------------------------------------------------
// Triangle scanline span
// Sorts three vertices by y and returns the horizontal span of one row.
// ----------------------------------------------------------------------------
// The block accepts one query per cycle and returns one result per query in
// order. Its stages are input capture, vertex sort, edge setup, multiply, a
// divider that retires two quotient bits per stage for both edges, and the
// output register. Each stage holds its item only while the stage after it
// is full and stalled, so bubbles close up and the input stalls only when
// every stage is occupied.
`include "triangle_scanline_span_defines.svh"

module triangle_scanline_span
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  tss_pkg::coord_t vert_a_x,
    input  tss_pkg::coord_t vert_a_y,
    input  tss_pkg::coord_t vert_b_x,
    input  tss_pkg::coord_t vert_b_y,
    input  tss_pkg::coord_t vert_c_x,
    input  tss_pkg::coord_t vert_c_y,
    input  tss_pkg::coord_t scan_row,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            row_covered,
    output tss_pkg::coord_t span_left,
    output tss_pkg::coord_t span_right
);

    import tss_pkg::*;

    query_t      q_reg;
    sorted_t     s_reg;
    sorted_t     s_next;
    prep_stage_t p_reg;
    prep_stage_t p_next;
    div_stage_t  d_reg;
    div_stage_t  d_next;
    div_stage_t  div_reg [DIV_STAGES];
    div_stage_t  div_next [DIV_STAGES];
    div_stage_t  div_in [DIV_STAGES];

    logic q_v_reg;
    logic s_v_reg;
    logic p_v_reg;
    logic d_v_reg;
    logic [DIV_STAGES-1:0] div_v_reg;
    logic o_v_reg;

    logic q_en;
    logic s_en;
    logic p_en;
    logic d_en;
    logic [DIV_STAGES-1:0] div_en;
    logic o_en;

    logic   covered_reg;
    logic   covered_next;
    coord_t left_reg;
    coord_t left_next;
    coord_t right_reg;
    coord_t right_next;

    logic [1:0] rank_a;
    logic [1:0] rank_b;

    // Each stage moves when it is empty or the stage after it moves.
    always_comb
    begin
        o_en = !o_v_reg || !out_stall;
        div_en[DIV_STAGES-1] = !div_v_reg[DIV_STAGES-1] || o_en;
        for (int s = DIV_STAGES - 2; s >= 0; s--)
        begin
            div_en[s] = !div_v_reg[s] || div_en[s+1];
        end
        d_en = !d_v_reg || div_en[0];
        p_en = !p_v_reg || d_en;
        s_en = !s_v_reg || p_en;
        q_en = !q_v_reg || s_en;
    end

    assign in_stall = !q_en;

    // Stable sort: an earlier vertex goes first unless its y is strictly larger.
    always_comb
    begin
        logic ab;
        logic ac;
        logic bc;
        ab = q_reg.a.y > q_reg.b.y;
        ac = q_reg.a.y > q_reg.c.y;
        bc = q_reg.b.y > q_reg.c.y;
        rank_a = {1'b0, ab} + {1'b0, ac};
        rank_b = {1'b0, !ab} + {1'b0, bc};
        s_next.top = q_reg.c;
        s_next.mid = q_reg.c;
        s_next.bot = q_reg.c;
        if (rank_a == 2'd0)
        begin
            s_next.top = q_reg.a;
        end
        else if (rank_b == 2'd0)
        begin
            s_next.top = q_reg.b;
        end
        if (rank_a == 2'd1)
        begin
            s_next.mid = q_reg.a;
        end
        else if (rank_b == 2'd1)
        begin
            s_next.mid = q_reg.b;
        end
        if (rank_a == 2'd2)
        begin
            s_next.bot = q_reg.a;
        end
        else if (rank_b == 2'd2)
        begin
            s_next.bot = q_reg.b;
        end
        s_next.row = q_reg.row;
        s_next.covered = (q_reg.row >= s_next.top.y) && (q_reg.row <= s_next.bot.y);
        s_next.upper = q_reg.row < s_next.mid.y;
    end

    always_comb
    begin
        p_next.covered = s_reg.covered;
        if (s_reg.upper)
        begin
            p_next.e1 = edge_prep(s_reg.top, s_reg.mid, s_reg.row);
        end
        else
        begin
            p_next.e1 = edge_prep(s_reg.mid, s_reg.bot, s_reg.row);
        end
        p_next.e2 = edge_prep(s_reg.top, s_reg.bot, s_reg.row);
    end

    always_comb
    begin
        prod_t m1;
        prod_t m2;
        m1 = PROD_BITS'(p_reg.e1.mag) * PROD_BITS'(p_reg.e1.dr);
        m2 = PROD_BITS'(p_reg.e2.mag) * PROD_BITS'(p_reg.e2.dr);
        d_next.covered = p_reg.covered;
        d_next.e1.neg = p_reg.e1.neg;
        d_next.e1.ax = p_reg.e1.ax;
        d_next.e1.dvs = p_reg.e1.dvs;
        d_next.e1.rem = m1[PROD_BITS-1:COORD_BITS];
        d_next.e1.num = m1[COORD_BITS-1:0];
        d_next.e2.neg = p_reg.e2.neg;
        d_next.e2.ax = p_reg.e2.ax;
        d_next.e2.dvs = p_reg.e2.dvs;
        d_next.e2.rem = m2[PROD_BITS-1:COORD_BITS];
        d_next.e2.num = m2[COORD_BITS-1:0];
    end

    genvar gs;
    generate
        for (gs = 0; gs < DIV_STAGES; gs++)
        begin : g_div_in
            if (gs == 0)
            begin : g_first
                assign div_in[gs] = d_reg;
            end
            else
            begin : g_rest
                assign div_in[gs] = div_reg[gs-1];
            end
        end
    endgenerate

    always_comb
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            div_next[s] = div_in[s];
            for (int j = 0; j < DIV_STEPS_PER_STAGE; j++)
            begin
                if (s * DIV_STEPS_PER_STAGE + j < COORD_BITS)
                begin
                    div_next[s].e1 = div_step(div_next[s].e1);
                    div_next[s].e2 = div_step(div_next[s].e2);
                end
            end
        end
    end

    always_comb
    begin
        coord_t x1;
        coord_t x2;
        x1 = lane_x(div_reg[DIV_STAGES-1].e1);
        x2 = lane_x(div_reg[DIV_STAGES-1].e2);
        covered_next = div_reg[DIV_STAGES-1].covered;
        if (!covered_next)
        begin
            left_next = '0;
            right_next = '0;
        end
        else if (x1 > x2)
        begin
            left_next = x2;
            right_next = x1;
        end
        else
        begin
            left_next = x1;
            right_next = x2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
            p_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            div_v_reg <= '0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (q_en)
            begin
                q_v_reg <= in_valid;
            end
            if (s_en)
            begin
                s_v_reg <= q_v_reg;
            end
            if (p_en)
            begin
                p_v_reg <= s_v_reg;
            end
            if (d_en)
            begin
                d_v_reg <= p_v_reg;
            end
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                if (div_en[s])
                begin
                    div_v_reg[s] <= (s == 0) ? d_v_reg : div_v_reg[(s == 0) ? 0 : s - 1];
                end
            end
            if (o_en)
            begin
                o_v_reg <= div_v_reg[DIV_STAGES-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_en)
        begin
            q_reg.a.x <= vert_a_x;
            q_reg.a.y <= vert_a_y;
            q_reg.b.x <= vert_b_x;
            q_reg.b.y <= vert_b_y;
            q_reg.c.x <= vert_c_x;
            q_reg.c.y <= vert_c_y;
            q_reg.row <= scan_row;
        end
        if (s_en)
        begin
            s_reg <= s_next;
        end
        if (p_en)
        begin
            p_reg <= p_next;
        end
        if (d_en)
        begin
            d_reg <= d_next;
        end
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (div_en[s])
            begin
                div_reg[s] <= div_next[s];
            end
        end
        if (o_en)
        begin
            covered_reg <= covered_next;
            left_reg <= left_next;
            right_reg <= right_next;
        end
    end

    assign out_valid = o_v_reg;
    assign row_covered = covered_reg;
    assign span_left = left_reg;
    assign span_right = right_reg;

    `TSS_ASSERT_IMP(a_stall_full, in_stall, out_valid && out_stall && q_v_reg,
        "input stalled while the pipeline has room")
    `TSS_ASSERT_NXT(a_capture, in_valid && !in_stall, q_v_reg,
        "accepted transfer not captured")
    `TSS_ASSERT_IMP(a_order, out_valid && row_covered, span_left <= span_right,
        "span endpoints out of order")
    `TSS_ASSERT_IMP(a_uncovered, out_valid && !row_covered,
        span_left == '0 && span_right == '0, "uncovered row with nonzero span")
    `TSS_ASSERT_IMP(a_div_rem,
        div_v_reg[DIV_STAGES-1] && div_reg[DIV_STAGES-1].covered,
        div_reg[DIV_STAGES-1].e2.rem < div_reg[DIV_STAGES-1].e2.dvs,
        "divider remainder not below divisor")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Triangle scanline span testbench
// Sends triangle row queries through the span block while both sides of the
// handshake idle at random. A local span calculator or a hand-set value
// predicts each result; every output transfer is checked in order against it.
// ----------------------------------------------------------------------------
module tb;

    import tss_pkg::*;

    localparam int RANDOM_QUERIES = 2000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic   covered;
        coord_t lo_x;
        coord_t hi_x;
    } span_t;

    typedef struct packed {
        query_t q;
        logic   typed;
        span_t  want;
    } directed_row_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    coord_t vert_a_x;
    coord_t vert_a_y;
    coord_t vert_b_x;
    coord_t vert_b_y;
    coord_t vert_c_x;
    coord_t vert_c_y;
    coord_t scan_row;
    logic   out_valid;
    logic   out_stall;
    logic   row_covered;
    coord_t span_left;
    coord_t span_right;

    span_t         pending_spans[$];
    directed_row_t directed_rows[$];

    int  n_sent;
    int  n_checked = 0;
    int  n_inside = 0;
    int  n_fail = 0;
    int  n_cycles = 0;
    int  n_backpressure = 0;
    bit  hold_active = 1'b0;
    bit  hold_done = 1'b0;

    triangle_scanline_span i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .vert_a_x    (vert_a_x),
        .vert_a_y    (vert_a_y),
        .vert_b_x    (vert_b_x),
        .vert_b_y    (vert_b_y),
        .vert_c_x    (vert_c_x),
        .vert_c_y    (vert_c_y),
        .scan_row    (scan_row),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_covered (row_covered),
        .span_left   (span_left),
        .span_right  (span_right)
    );

    always #10 clk = ~clk;

    function automatic longint edge_cross_x(longint ax, longint ay, longint bx, longint by,
                                            longint row);
        if (ay == by)
        begin
            return ax;
        end
        return ax + ((bx - ax) * (row - ay)) / (by - ay);
    endfunction

    function automatic span_t scan_span(query_t q);
        longint xs[3];
        longint ys[3];
        longint row;
        longint tx;
        longint x1;
        longint x2;
        span_t s;
        xs[0] = q.a.x;
        ys[0] = q.a.y;
        xs[1] = q.b.x;
        ys[1] = q.b.y;
        xs[2] = q.c.x;
        ys[2] = q.c.y;
        row = q.row;
        for (int i = 1; i < 3; i++)
        begin
            for (int j = i; j > 0 && ys[j-1] > ys[j]; j--)
            begin
                tx = xs[j]; xs[j] = xs[j-1]; xs[j-1] = tx;
                tx = ys[j]; ys[j] = ys[j-1]; ys[j-1] = tx;
            end
        end
        s = '0;
        if (row < ys[0] || row > ys[2])
        begin
            return s;
        end
        if (row < ys[1])
        begin
            x1 = edge_cross_x(xs[0], ys[0], xs[1], ys[1], row);
        end
        else
        begin
            x1 = edge_cross_x(xs[1], ys[1], xs[2], ys[2], row);
        end
        x2 = edge_cross_x(xs[0], ys[0], xs[2], ys[2], row);
        if (x1 > x2)
        begin
            tx = x1; x1 = x2; x2 = tx;
        end
        s.covered = 1'b1;
        s.lo_x = coord_t'(x1);
        s.hi_x = coord_t'(x2);
        return s;
    endfunction

    function automatic query_t make_query(int ax, int ay, int bx, int by, int cx, int cy,
                                          int row);
        query_t q;
        q.a.x = coord_t'(ax);
        q.a.y = coord_t'(ay);
        q.b.x = coord_t'(bx);
        q.b.y = coord_t'(by);
        q.c.x = coord_t'(cx);
        q.c.y = coord_t'(cy);
        q.row = coord_t'(row);
        return q;
    endfunction

    task automatic add_row(int ax, int ay, int bx, int by, int cx, int cy, int row,
                           bit typed, bit cov, int lo, int hi);
        directed_row_t r;
        r.q = make_query(ax, ay, bx, by, cx, cy, row);
        r.typed = typed;
        r.want.covered = cov;
        r.want.lo_x = coord_t'(lo);
        r.want.hi_x = coord_t'(hi);
        directed_rows.insert(directed_rows.size(), r);
    endtask

    function automatic bit quiet_phase();
        return (n_sent >= 1000 && n_sent < 1300) || (n_sent >= RANDOM_QUERIES - 200);
    endfunction

    // Mostly rows inside the triangle, with ties, tiny triangles, rows on a
    // vertex and fully random queries mixed in.
    function automatic query_t random_query();
        query_t q;
        int mode;
        int base;
        int ymin;
        int ymax;
        mode = $urandom_range(0, 9);
        q.a.x = coord_t'($urandom_range(0, 4095));
        q.b.x = coord_t'($urandom_range(0, 4095));
        q.c.x = coord_t'($urandom_range(0, 4095));
        q.a.y = coord_t'($urandom_range(0, 4095));
        q.b.y = coord_t'($urandom_range(0, 4095));
        q.c.y = coord_t'($urandom_range(0, 4095));
        q.row = coord_t'($urandom_range(0, 4095));
        if (mode == 6)
        begin
            base = $urandom_range(0, 4087);
            q.a.y = coord_t'(base + $urandom_range(0, 8));
            q.b.y = coord_t'(base + $urandom_range(0, 8));
            q.c.y = coord_t'(base + $urandom_range(0, 8));
        end
        else if (mode == 7)
        begin
            case ($urandom_range(0, 3))
                0: q.b.y = q.a.y;
                1: q.c.y = q.a.y;
                2: q.c.y = q.b.y;
                default:
                begin
                    q.b.y = q.a.y;
                    q.c.y = q.a.y;
                end
            endcase
        end
        ymin = q.a.y;
        ymax = q.a.y;
        if (q.b.y < ymin) ymin = q.b.y;
        if (q.c.y < ymin) ymin = q.c.y;
        if (q.b.y > ymax) ymax = q.b.y;
        if (q.c.y > ymax) ymax = q.c.y;
        if (mode == 8)
        begin
            case ($urandom_range(0, 2))
                0: q.row = q.a.y;
                1: q.row = q.b.y;
                default: q.row = q.c.y;
            endcase
        end
        else if (mode == 6 && $urandom_range(0, 3) == 0)
        begin
            q.row = coord_t'($urandom_range(ymin > 2 ? ymin - 2 : 0,
                                            ymax < 4093 ? ymax + 2 : 4095));
        end
        else if (mode != 9)
        begin
            q.row = coord_t'($urandom_range(ymin, ymax));
        end
        return q;
    endfunction

    task automatic send_query(input query_t q, input span_t want);
        in_valid <= 1'b1;
        vert_a_x <= q.a.x;
        vert_a_y <= q.a.y;
        vert_b_x <= q.b.x;
        vert_b_y <= q.b.y;
        vert_c_x <= q.c.x;
        vert_c_y <= q.c.y;
        scan_row <= q.row;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_spans.insert(pending_spans.size(), want);
        n_sent++;
        if (!quiet_phase() && !hold_active && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Receiver side: random stall bursts, and once a long hold-off so that
    // the pipeline fills and pushes back on the sender.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && n_sent >= 600)
            begin
                hold_active = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_active = 1'b0;
                hold_done = 1'b1;
            end
            else if (!quiet_phase() && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        span_t want;
        if (rst_n)
        begin
            n_cycles++;
            if (n_cycles > CYCLE_LIMIT)
            begin
                $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            if (in_valid && in_stall)
            begin
                n_backpressure++;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_spans.size() == 0)
                begin
                    $display("%0t: unexpected transfer, actual covered=%0d left=%0d right=%0d",
                             $time, row_covered, span_left, span_right);
                    n_fail++;
                end
                else
                begin
                    want = pending_spans.pop_front();
                    n_checked++;
                    if (want.covered)
                    begin
                        n_inside++;
                    end
                    if (row_covered !== want.covered)
                    begin
                        $display("%0t: row_covered expected %0d actual %0d",
                                 $time, want.covered, row_covered);
                        n_fail++;
                    end
                    if (span_left !== want.lo_x)
                    begin
                        $display("%0t: span_left expected %0d actual %0d",
                                 $time, want.lo_x, span_left);
                        n_fail++;
                    end
                    if (span_right !== want.hi_x)
                    begin
                        $display("%0t: span_right expected %0d actual %0d",
                                 $time, want.hi_x, span_right);
                        n_fail++;
                    end
                end
            end
        end
    end

    initial
    begin
        directed_row_t r;
        query_t q;
        rst_n = 1'b0;
        in_valid = 1'b0;
        vert_a_x = '0;
        vert_a_y = '0;
        vert_b_x = '0;
        vert_b_y = '0;
        vert_c_x = '0;
        vert_c_y = '0;
        scan_row = '0;
        n_sent = 0;

        add_row(0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
        add_row(4095, 4095, 4095, 4095, 4095, 4095, 4095, 1, 1, 4095, 4095);
        add_row(0, 0, 4095, 4095, 0, 4095, 0, 0, 0, 0, 0);
        add_row(0, 0, 4095, 4095, 0, 4095, 2048, 0, 0, 0, 0);
        add_row(0, 0, 4095, 4095, 0, 4095, 4095, 0, 0, 0, 0);
        add_row(10, 100, 200, 300, 50, 200, 99, 1, 0, 0, 0);
        add_row(10, 100, 200, 300, 50, 200, 301, 1, 0, 0, 0);
        add_row(4095, 1, 4095, 5, 4095, 3, 0, 1, 0, 0, 0);
        add_row(4095, 4094, 0, 4000, 17, 4090, 4095, 1, 0, 0, 0);
        add_row(100, 50, 10, 50, 300, 50, 50, 1, 1, 10, 100);
        add_row(100, 50, 10, 50, 300, 50, 51, 1, 0, 0, 0);
        add_row(400, 10, 100, 10, 250, 200, 10, 0, 0, 0, 0);
        add_row(400, 10, 100, 10, 250, 200, 100, 0, 0, 0, 0);
        add_row(250, 10, 400, 200, 100, 200, 200, 0, 0, 0, 0);
        add_row(250, 10, 400, 200, 100, 200, 105, 0, 0, 0, 0);
        add_row(1000, 0, 0, 3, 1000, 3, 1, 0, 0, 0, 0);
        add_row(1000, 0, 0, 3, 1000, 3, 2, 0, 0, 0, 0);
        add_row(5, 900, 3000, 600, 4000, 20, 20, 0, 0, 0, 0);
        add_row(5, 900, 3000, 600, 4000, 20, 600, 0, 0, 0, 0);
        add_row(5, 900, 3000, 600, 4000, 20, 700, 0, 0, 0, 0);
        add_row(5, 900, 3000, 600, 4000, 20, 900, 0, 0, 0, 0);
        add_row(4095, 0, 0, 4095, 4095, 4095, 1, 0, 0, 0, 0);
        add_row(4095, 0, 0, 4095, 4095, 4095, 4094, 0, 0, 0, 0);
        add_row(7, 300, 9, 100, 11, 100, 100, 0, 0, 0, 0);
        add_row(7, 300, 9, 100, 11, 100, 299, 0, 0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            send_query(r.q, r.typed ? r.want : scan_span(r.q));
        end

        repeat (RANDOM_QUERIES)
        begin
            q = random_query();
            send_query(q, scan_span(q));
        end
        in_valid <= 1'b0;

        while (pending_spans.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d span queries, %0d rows inside a triangle and %0d outside.",
                 n_checked, n_inside, n_checked - n_inside);
        $display("The input was held off for %0d cycles while the output stalled.",
                 n_backpressure);
        if (n_fail == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
